// ----- hw/rtl/kal_pkg.sv -----
// ----------------------------------------------------------------------------
// kal_pkg
// Shared types, constants and helpers for the k-th ancestor lifting block.
// ----------------------------------------------------------------------------
package kal_pkg;

  localparam int unsigned MAX_NODES = 1024;
  localparam int unsigned LEVELS    = 11;
  localparam int unsigned NODE_W    = $clog2(MAX_NODES);
  localparam int unsigned CFG_W     = 11;
  localparam int unsigned STEP_W    = 11;
  localparam int unsigned LVL_W     = $clog2(LEVELS);
  localparam int unsigned ENT_W     = NODE_W + 1;
  localparam int unsigned TBL_DEPTH = MAX_NODES * LEVELS;
  localparam int unsigned ADDR_W    = $clog2(TBL_DEPTH);

  // Table entry: top bit set means no ancestor
  localparam logic [ENT_W-1:0] ENT_NONE  = {1'b1, {NODE_W{1'b0}}};
  localparam logic [CFG_W-1:0] CNT_RESET = CFG_W'(MAX_NODES);

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e              command;
    logic [NODE_W-1:0] node;
    logic [NODE_W-1:0] parent_node;
    logic              has_parent;
    logic              last_load;
    logic [STEP_W-1:0] step_count;
  } cmd_t;

  typedef struct packed {
    logic [NODE_W-1:0] ancestor;
    logic              found;
  } res_t;

  function automatic logic [ADDR_W-1:0] tbl_addr(input logic [LVL_W-1:0]  lvl,
                                                  input logic [NODE_W-1:0] n);
    tbl_addr = (ADDR_W'(lvl) << NODE_W) | ADDR_W'(n);
  endfunction

endpackage

// ----- hw/rtl/kal_ram.sv -----
// ----------------------------------------------------------------------------
// kal_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module kal_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/kth_ancestor_binary_lifting.sv -----
// ----------------------------------------------------------------------------
// kth_ancestor_binary_lifting
// Binary-lifting k-th ancestor engine with the jump table in one RAM.
// ----------------------------------------------------------------------------
// Usage:
//   in_item_i is taken at a clock edge with start high and busy low.
//   A load of an in-range node writes one parent entry in the accept cycle
//   and gives no result; with last_load set and node_count nonzero the block
//   then builds levels 1 to 10 for each node, holding busy high through an
//   issue, a first and, for a valid entry, a second state per node and level.
//   A query answers on result_o with res_valid_o high for exactly one cycle:
//   in the first cycle after the accepting edge for an out-of-range node,
//   else at the end of a walk over the bits of k, one table read per set bit
//   through the single RAM read port. The next item is taken at the earliest
//   at the edge that ends the result cycle.
//   The result port has no back-pressure: each result is seen once.
//   node_count is written over cfg_* while busy is low (cfg_ready_o).
//   Reset clears the control and sets node_count to 1024; the table holds
//   no valid contents until loaded and built.
// ----------------------------------------------------------------------------
module kth_ancestor_binary_lifting (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  kal_pkg::cmd_t              in_item_i,
  output logic                       res_valid_o,
  output kal_pkg::res_t              result_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [kal_pkg::CFG_W-1:0]  cfg_data_i
);

  import kal_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_B_ISSUE,
    S_B_FIRST,
    S_B_SECOND,
    S_Q_STEP,
    S_Q_WAIT
  } state_e;

  state_e            state_q;
  logic [LVL_W-1:0]  lvl_q;
  logic [NODE_W-1:0] idx_q;
  logic [NODE_W-1:0] cur_q;
  logic [STEP_W-1:0] steps_q;
  logic [CFG_W-1:0]  node_count_q;
  logic              res_valid_q;
  res_t              res_q;

  logic [CFG_W-1:0]  cnt;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic [ENT_W-1:0]  wdata;
  logic [ENT_W-1:0]  rdata;
  logic              ent_bad;
  logic              last_idx;
  logic              last_lvl;
  logic              accept;

  assign cnt = (node_count_q > CFG_W'(MAX_NODES)) ? CFG_W'(MAX_NODES) : node_count_q;
  assign ent_bad  = rdata[NODE_W] || (CFG_W'(rdata[NODE_W-1:0]) >= cnt);
  assign last_idx = (CFG_W'(idx_q) == (cnt - CFG_W'(1)));
  assign last_lvl = (lvl_q == LVL_W'(LEVELS - 1));
  assign accept   = start && !busy;

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = !busy;
  assign res_valid_o = res_valid_q;
  assign result_o    = res_q;

  kal_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TBL_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept && (in_item_i.command == CMD_LOAD) &&
            (CFG_W'(in_item_i.node) < cnt)) begin
          we    = 1'b1;
          waddr = tbl_addr('0, in_item_i.node);
          wdata = (in_item_i.has_parent && (CFG_W'(in_item_i.parent_node) < cnt)) ?
                  {1'b0, in_item_i.parent_node} : ENT_NONE;
        end
      end
      S_B_ISSUE: begin
        raddr = tbl_addr(lvl_q - LVL_W'(1), idx_q);
      end
      S_B_FIRST: begin
        if (ent_bad) begin
          we    = 1'b1;
          waddr = tbl_addr(lvl_q, idx_q);
          wdata = ENT_NONE;
        end else begin
          raddr = tbl_addr(lvl_q - LVL_W'(1), rdata[NODE_W-1:0]);
        end
      end
      S_B_SECOND: begin
        we    = 1'b1;
        waddr = tbl_addr(lvl_q, idx_q);
        wdata = rdata;
      end
      S_Q_STEP: begin
        if (steps_q[0]) begin
          raddr = tbl_addr(lvl_q, cur_q);
        end
      end
      S_Q_WAIT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      lvl_q        <= '0;
      idx_q        <= '0;
      cur_q        <= '0;
      steps_q      <= '0;
      node_count_q <= CNT_RESET;
      res_valid_q  <= 1'b0;
      res_q        <= '0;
    end else begin
      res_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (cfg_valid_i) begin
            node_count_q <= cfg_data_i;
          end
          if (accept) begin
            if (in_item_i.command == CMD_LOAD) begin
              if (in_item_i.last_load && (cnt != '0)) begin
                lvl_q   <= LVL_W'(1);
                idx_q   <= '0;
                state_q <= S_B_ISSUE;
              end
            end else if (CFG_W'(in_item_i.node) < cnt) begin
              cur_q   <= in_item_i.node;
              steps_q <= in_item_i.step_count;
              lvl_q   <= '0;
              state_q <= S_Q_STEP;
            end else begin
              res_valid_q <= 1'b1;
              res_q       <= '0;
            end
          end
        end
        S_B_ISSUE: begin
          state_q <= S_B_FIRST;
        end
        S_B_FIRST, S_B_SECOND: begin
          if ((state_q == S_B_FIRST) && !ent_bad) begin
            state_q <= S_B_SECOND;
          end else if (last_idx) begin
            idx_q <= '0;
            if (last_lvl) begin
              state_q <= S_IDLE;
            end else begin
              lvl_q   <= lvl_q + LVL_W'(1);
              state_q <= S_B_ISSUE;
            end
          end else begin
            idx_q   <= idx_q + NODE_W'(1);
            state_q <= S_B_ISSUE;
          end
        end
        S_Q_STEP: begin
          if (steps_q == '0) begin
            res_valid_q    <= 1'b1;
            res_q.ancestor <= cur_q;
            res_q.found    <= 1'b1;
            state_q        <= S_IDLE;
          end else if (steps_q[0]) begin
            state_q <= S_Q_WAIT;
          end else begin
            steps_q <= steps_q >> 1;
            lvl_q   <= lvl_q + LVL_W'(1);
          end
        end
        S_Q_WAIT: begin
          if (ent_bad) begin
            res_valid_q <= 1'b1;
            res_q       <= '0;
            state_q     <= S_IDLE;
          end else begin
            cur_q   <= rdata[NODE_W-1:0];
            steps_q <= steps_q >> 1;
            lvl_q   <= lvl_q + LVL_W'(1);
            state_q <= S_Q_STEP;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Results come only from the end of a walk or a rejected query
  a_res_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> ($past(state_q) == S_Q_STEP) || ($past(state_q) == S_Q_WAIT) ||
                    ($past(accept) && ($past(in_item_i.command) == CMD_QUERY)))
    else $error("result without a query");

  // A found ancestor is always a node in use
  a_found_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && result_o.found) |-> (CFG_W'(result_o.ancestor) < cnt))
    else $error("found ancestor out of range");

  // Queries never write the table
  a_query_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_Q_STEP) || (state_q == S_Q_WAIT)) |-> !we)
    else $error("table write during query");

  // Build writes only levels above zero
  a_build_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we && busy) |-> (lvl_q != '0))
    else $error("build wrote level zero");

endmodule
